>>> design/sdu_pkg.sv
// Package of the symmetric demons update vector block.
// Holds widths, word types and pipeline payload types; depends on nothing.
package sdu_pkg;

    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int SP_W    = 16;
    localparam int G2_W    = 27;
    localparam int D_W     = 25;
    localparam int MG_W    = 26;
    localparam int MD_W    = 24;
    localparam int DSQ_W   = 48;
    localparam int GSQ_W   = 52;
    localparam int GSUM_W  = 54;
    localparam int N_W     = 50;
    localparam int SCALE_SH = 10;
    localparam int QD_W    = 58;
    localparam int DEN_W   = 59;
    localparam int OVF_SH  = 14;
    localparam int FRAC_SH = 18;
    localparam int QF_W    = 32;
    localparam int HI_W    = N_W - OVF_SH;
    localparam logic [SP_W-1:0] SPACING_RESET = 16'd256;
    localparam logic [OUT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic signed [IN_W-1:0] static_grad_x;
        logic signed [IN_W-1:0] static_grad_y;
        logic signed [IN_W-1:0] static_grad_z;
        logic [IN_W-1:0] warped_center;
        logic [IN_W-1:0] warped_x_prev;
        logic [IN_W-1:0] warped_x_next;
        logic [IN_W-1:0] warped_y_prev;
        logic [IN_W-1:0] warped_y_next;
        logic [IN_W-1:0] warped_z_prev;
        logic [IN_W-1:0] warped_z_next;
        logic [IN_W-1:0] static_value;
    } voxel_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] delta_x;
        logic signed [OUT_W-1:0] delta_y;
        logic signed [OUT_W-1:0] delta_z;
        logic updated;
    } delta_t;

    typedef struct packed {
        logic [DSQ_W-1:0] dsq;
        logic [2:0][GSQ_W-1:0] gsq;
        logic [2:0][N_W-1:0] n;
        logic [2:0] neg;
        logic any;
    } front_t;

    typedef struct packed {
        logic [GSUM_W-1:0] gsum;
        logic [2:0][N_W-1:0] n;
        logic [2:0] neg;
        logic any;
    } mid_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic any;
    } lane_t;

endpackage

>>> design/sdu_if.sv
// Handshake interfaces of the symmetric demons update vector block.
// Depends on sdu_pkg for the word types.
interface sdu_voxel_if;
    logic valid;
    logic ready;
    sdu_pkg::voxel_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdu_delta_if;
    logic valid;
    logic ready;
    sdu_pkg::delta_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdu_cfg_if;
    logic valid;
    logic ready;
    logic [sdu_pkg::SP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/symmetric_demons_update_vector.sv
// Top level of the symmetric demons update vector block.
// Depends on sdu_pkg, sdu_if, sdu_front and sdu_div_cell.
//
//  channel  modport  words
//  voxel    sink     one voxel, eleven fields
//  delta    source   one update vector per voxel
//  cfg      sink     spacing register write, always ready
//
// Voxels are taken every cycle unless delta stalls, passing two front stages,
// a 58-cell chain dividing the squared difference by spacing, one sum stage,
// three parallel 32-cell chains forming the vector, and the output register.
// Reset clears every valid bit and sets spacing to 1.0.
// A stall at delta freezes the whole pipeline, so voxel ready follows it.
module symmetric_demons_update_vector (
    input logic         clk,
    input logic         rst_n,
    sdu_voxel_if.sink   voxel,
    sdu_delta_if.source delta,
    sdu_cfg_if.sink     cfg
);

    localparam int MID_W  = $bits(sdu_pkg::mid_t);
    localparam int LANE_W = $bits(sdu_pkg::lane_t);

    logic                      en;
    logic [sdu_pkg::SP_W-1:0]  spacing_reg;
    logic [sdu_pkg::SP_W-1:0]  sdiv;
    logic                      f_valid;
    sdu_pkg::front_t           f_data;
    sdu_pkg::mid_t             mid_in, mid_out;

    logic [sdu_pkg::QD_W:0]                       dv;
    logic [sdu_pkg::QD_W:0][sdu_pkg::QD_W-1:0]    dnum;
    logic [sdu_pkg::QD_W:0][sdu_pkg::SP_W-1:0]    drem;
    logic [sdu_pkg::QD_W:0][sdu_pkg::QD_W-1:0]    dquo;
    logic [sdu_pkg::QD_W:0][sdu_pkg::SP_W-1:0]    ddiv;
    logic [sdu_pkg::QD_W:0][MID_W-1:0]            dpay;

    logic                           den_valid_reg;
    logic [sdu_pkg::DEN_W-1:0]      den_reg;
    logic [2:0][sdu_pkg::N_W-1:0]   den_n_reg;
    logic [2:0]                     den_neg_reg;
    logic                           den_any_reg;
    logic [sdu_pkg::DEN_W-1:0]      fdiv;

    logic [2:0][sdu_pkg::QF_W:0]                     fv;
    logic [2:0][sdu_pkg::QF_W:0][sdu_pkg::QF_W-1:0]  fnum;
    logic [2:0][sdu_pkg::QF_W:0][sdu_pkg::DEN_W-1:0] frem;
    logic [2:0][sdu_pkg::QF_W:0][sdu_pkg::QF_W-1:0]  fquo;
    logic [2:0][sdu_pkg::QF_W:0][sdu_pkg::DEN_W-1:0] fdv;
    logic [2:0][sdu_pkg::QF_W:0][LANE_W-1:0]         fpay;

    logic [2:0][sdu_pkg::OUT_W-1:0] res;
    sdu_pkg::lane_t [2:0]           lane_out;
    logic                           out_valid_reg;
    sdu_pkg::delta_t                out_reg, out_next;

    assign en          = !out_valid_reg || delta.ready;
    assign voxel.ready = en;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= sdu_pkg::SPACING_RESET;
        end
        else if (cfg.valid)
        begin
            spacing_reg <= cfg.data;
        end
    end

    assign sdiv = (spacing_reg == '0) ? sdu_pkg::SP_W'(1) : spacing_reg;

    sdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (voxel.valid),
        .in_data   (voxel.data),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    always_comb
    begin
        mid_in.gsum = sdu_pkg::GSUM_W'(f_data.gsq[0]) + sdu_pkg::GSUM_W'(f_data.gsq[1])
                    + sdu_pkg::GSUM_W'(f_data.gsq[2]);
        mid_in.n    = f_data.n;
        mid_in.neg  = f_data.neg;
        mid_in.any  = f_data.any;
    end

    assign dv[0]   = f_valid;
    assign dnum[0] = {f_data.dsq, {sdu_pkg::SCALE_SH{1'b0}}};
    assign drem[0] = '0;
    assign dquo[0] = '0;
    assign ddiv[0] = sdiv;
    assign dpay[0] = mid_in;

    for (genvar i = 0; i < sdu_pkg::QD_W; i++)
    begin : g_dcell
        sdu_div_cell #(
            .NUM_W (sdu_pkg::QD_W),
            .DIV_W (sdu_pkg::SP_W),
            .QUO_W (sdu_pkg::QD_W),
            .PAY_W (MID_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[i]),
            .in_num    (dnum[i]),
            .in_rem    (drem[i]),
            .in_quo    (dquo[i]),
            .in_div    (ddiv[i]),
            .in_pay    (dpay[i]),
            .out_valid (dv[i+1]),
            .out_num   (dnum[i+1]),
            .out_rem   (drem[i+1]),
            .out_quo   (dquo[i+1]),
            .out_div   (ddiv[i+1]),
            .out_pay   (dpay[i+1])
        );
    end

    assign mid_out = dpay[sdu_pkg::QD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            den_valid_reg <= dv[sdu_pkg::QD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg     <= sdu_pkg::DEN_W'(dquo[sdu_pkg::QD_W])
                         + sdu_pkg::DEN_W'(mid_out.gsum);
            den_n_reg   <= mid_out.n;
            den_neg_reg <= mid_out.neg;
            den_any_reg <= mid_out.any;
        end
    end

    // With a zero denominator every gradient is zero, so a divisor of one
    // yields the zero vector.
    assign fdiv = (den_reg == '0) ? sdu_pkg::DEN_W'(1) : den_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        sdu_pkg::lane_t lane_in;

        always_comb
        begin
            lane_in.neg = den_neg_reg[a];
            lane_in.ovf = sdu_pkg::DEN_W'(den_n_reg[a][sdu_pkg::N_W-1:sdu_pkg::OVF_SH])
                          >= fdiv;
            lane_in.any = den_any_reg;
        end

        assign fv[a][0]   = den_valid_reg;
        assign fnum[a][0] = {den_n_reg[a][sdu_pkg::OVF_SH-1:0], {sdu_pkg::FRAC_SH{1'b0}}};
        assign frem[a][0] = sdu_pkg::DEN_W'(den_n_reg[a][sdu_pkg::N_W-1:sdu_pkg::OVF_SH]);
        assign fquo[a][0] = '0;
        assign fdv[a][0]  = fdiv;
        assign fpay[a][0] = lane_in;

        for (genvar i = 0; i < sdu_pkg::QF_W; i++)
        begin : g_fcell
            sdu_div_cell #(
                .NUM_W (sdu_pkg::QF_W),
                .DIV_W (sdu_pkg::DEN_W),
                .QUO_W (sdu_pkg::QF_W),
                .PAY_W (LANE_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (fv[a][i]),
                .in_num    (fnum[a][i]),
                .in_rem    (frem[a][i]),
                .in_quo    (fquo[a][i]),
                .in_div    (fdv[a][i]),
                .in_pay    (fpay[a][i]),
                .out_valid (fv[a][i+1]),
                .out_num   (fnum[a][i+1]),
                .out_rem   (frem[a][i+1]),
                .out_quo   (fquo[a][i+1]),
                .out_div   (fdv[a][i+1]),
                .out_pay   (fpay[a][i+1])
            );
        end

        assign lane_out[a] = fpay[a][sdu_pkg::QF_W];

        always_comb
        begin
            if (lane_out[a].neg)
            begin
                if (lane_out[a].ovf || (fquo[a][sdu_pkg::QF_W] > sdu_pkg::NEG_MAX))
                begin
                    res[a] = sdu_pkg::NEG_MAX;
                end
                else
                begin
                    res[a] = -fquo[a][sdu_pkg::QF_W];
                end
            end
            else
            begin
                if (lane_out[a].ovf || (fquo[a][sdu_pkg::QF_W] > sdu_pkg::POS_MAX))
                begin
                    res[a] = sdu_pkg::POS_MAX;
                end
                else
                begin
                    res[a] = fquo[a][sdu_pkg::QF_W];
                end
            end
        end
    end

    always_comb
    begin
        out_next.delta_x = $signed(res[0]);
        out_next.delta_y = $signed(res[1]);
        out_next.delta_z = $signed(res[2]);
        out_next.updated = lane_out[0].any | lane_out[1].any | lane_out[2].any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fv[0][sdu_pkg::QF_W] & fv[1][sdu_pkg::QF_W]
                           & fv[2][sdu_pkg::QF_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign delta.valid = out_valid_reg;
    assign delta.data  = out_reg;

`ifndef SYNTHESIS
    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (delta.valid && !delta.data.updated) |->
        (delta.data.delta_x == 0 && delta.data.delta_y == 0 && delta.data.delta_z == 0))
        else $error("nonzero vector without update");
    a_den_zero_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (den_valid_reg && !den_any_reg) |-> (den_reg == '0))
        else $error("denominator nonzero for a flat voxel");
    a_den_zero_numer: assert property (@(posedge clk) disable iff (!rst_n)
        (den_valid_reg && den_reg == '0) |->
        (den_n_reg[0] == '0 && den_n_reg[1] == '0 && den_n_reg[2] == '0))
        else $error("zero denominator with nonzero numerator");
`endif

endmodule

>>> design/sdu_div_cell.sv
// One restoring division cell: one quotient bit per enabled cycle.
// Generic in widths; no package dependency.
module sdu_div_cell #(
    parameter int NUM_W = 32,
    parameter int DIV_W = 16,
    parameter int QUO_W = 32,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DIV_W-1:0] in_rem,
    input  logic [QUO_W-1:0] in_quo,
    input  logic [DIV_W-1:0] in_div,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_num,
    output logic [DIV_W-1:0] out_rem,
    output logic [QUO_W-1:0] out_quo,
    output logic [DIV_W-1:0] out_div,
    output logic [PAY_W-1:0] out_pay
);

    logic             valid_reg;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] div_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             fits;

    always_comb
    begin
        rem_sh   = {in_rem, in_num[NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, in_div};
        fits     = rem_sh >= {1'b0, in_div};
        rem_next = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_next = {in_quo[QUO_W-2:0], fits};
        num_next = in_num << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= in_div;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

>>> design/sdu_front.sv
// Front stages: total gradients and difference, then magnitudes and products.
// Depends on sdu_pkg.
module sdu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  sdu_pkg::voxel_t in_data,
    output logic            out_valid,
    output sdu_pkg::front_t out_data
);

    logic                              v1_reg, v2_reg;
    logic signed [sdu_pkg::G2_W-1:0]   g2_reg [3];
    logic signed [sdu_pkg::G2_W-1:0]   g2_next [3];
    logic signed [sdu_pkg::D_W-1:0]    d_reg, d_next;
    logic                              any_reg, any_next;
    sdu_pkg::front_t                   f_reg, f_next;
    logic [sdu_pkg::IN_W-1:0]          gin [3];
    logic [sdu_pkg::IN_W-1:0]          pin [3];
    logic [sdu_pkg::IN_W-1:0]          nin [3];
    logic [sdu_pkg::G2_W-1:0]          gabs [3];
    logic [sdu_pkg::D_W-1:0]           dabs;
    logic [sdu_pkg::MD_W-1:0]          dmag;
    logic [sdu_pkg::MG_W-1:0]          gmag [3];

    always_comb
    begin
        gin[0] = in_data.static_grad_x;
        gin[1] = in_data.static_grad_y;
        gin[2] = in_data.static_grad_z;
        pin[0] = in_data.warped_x_prev;
        pin[1] = in_data.warped_y_prev;
        pin[2] = in_data.warped_z_prev;
        nin[0] = in_data.warped_x_next;
        nin[1] = in_data.warped_y_next;
        nin[2] = in_data.warped_z_next;
        for (int a = 0; a < 3; a++)
        begin
            g2_next[a] = $signed({gin[a][sdu_pkg::IN_W-1], gin[a][sdu_pkg::IN_W-1],
                                  gin[a], 1'b0})
                       + ($signed({3'b000, nin[a]}) - $signed({3'b000, pin[a]}));
        end
        d_next   = $signed({1'b0, in_data.warped_center})
                 - $signed({1'b0, in_data.static_value});
        any_next = (d_next != '0) || (g2_next[0] != '0) || (g2_next[1] != '0)
                 || (g2_next[2] != '0);
    end

    always_comb
    begin
        dabs = d_reg[sdu_pkg::D_W-1] ? sdu_pkg::D_W'(-d_reg) : sdu_pkg::D_W'(d_reg);
        dmag = dabs[sdu_pkg::MD_W-1:0];
        f_next.dsq = sdu_pkg::DSQ_W'(dmag) * sdu_pkg::DSQ_W'(dmag);
        for (int a = 0; a < 3; a++)
        begin
            gabs[a] = g2_reg[a][sdu_pkg::G2_W-1] ? sdu_pkg::G2_W'(-g2_reg[a])
                                                 : sdu_pkg::G2_W'(g2_reg[a]);
            gmag[a] = gabs[a][sdu_pkg::MG_W-1:0];
            f_next.gsq[a] = sdu_pkg::GSQ_W'(gmag[a]) * sdu_pkg::GSQ_W'(gmag[a]);
            f_next.n[a]   = sdu_pkg::N_W'(gmag[a]) * sdu_pkg::N_W'(dmag);
            f_next.neg[a] = g2_reg[a][sdu_pkg::G2_W-1] ^ d_reg[sdu_pkg::D_W-1];
        end
        f_next.any = any_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2_reg  <= g2_next;
            d_reg   <= d_next;
            any_reg <= any_next;
            f_reg   <= f_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = f_reg;

endmodule

>>> tb/sdu_checker.sv
// Checker of the symmetric demons update vector block: watches the voxel, delta and cfg
// channels, predicts each update vector and compares it. Depends on sdu_pkg and sdu_if.
module sdu_checker (
    input logic              clk,
    input logic              rst_n,
    sdu_voxel_if.sink        voxel,
    sdu_delta_if.sink        delta,
    sdu_cfg_if.sink          cfg,
    output int               fail_count,
    output int               pending
);

    logic [sdu_pkg::SP_W-1:0] spacing_reg;
    sdu_pkg::delta_t          vectors_due[$];
    int                       n_updated;

    function automatic logic [31:0] demon_force(longint g2, longint d, logic [63:0] den);
        logic [63:0] mg;
        logic [63:0] md;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] res;
        logic        neg;
        mg = (g2 < 0) ? -g2 : g2;
        md = (d < 0) ? -d : d;
        n = mg * md;
        neg = (g2 < 0) != (d < 0);
        q = n / den;
        r = n % den;
        if (q >= 64'd16384)
        begin
            res = 64'd1 << 32;
        end
        else
        begin
            res = q;
            for (int i = 0; i < sdu_pkg::FRAC_SH; i++)
            begin
                r = r << 1;
                res = res << 1;
                if (r >= den)
                begin
                    r = r - den;
                    res[0] = 1'b1;
                end
            end
        end
        if (neg)
        begin
            if (res > (64'd1 << 31))
                res = 64'd1 << 31;
            res = -res;
        end
        else if (res > 64'h7FFF_FFFF)
        begin
            res = 64'h7FFF_FFFF;
        end
        return res[31:0];
    endfunction

    function automatic sdu_pkg::delta_t predict_vector(sdu_pkg::voxel_t v,
                                                       logic [sdu_pkg::SP_W-1:0] sp);
        longint          g2[3];
        longint          d;
        logic [63:0]     s;
        logic [63:0]     den;
        logic [63:0]     md;
        logic            any;
        sdu_pkg::delta_t o;
        logic [31:0]     f[3];
        s = (sp == 0) ? 64'd1 : {48'd0, sp};
        g2[0] = 2 * longint'(v.static_grad_x) + longint'(v.warped_x_next)
              - longint'(v.warped_x_prev);
        g2[1] = 2 * longint'(v.static_grad_y) + longint'(v.warped_y_next)
              - longint'(v.warped_y_prev);
        g2[2] = 2 * longint'(v.static_grad_z) + longint'(v.warped_z_next)
              - longint'(v.warped_z_prev);
        d = longint'(v.warped_center) - longint'(v.static_value);
        any = (d != 0) || (g2[0] != 0) || (g2[1] != 0) || (g2[2] != 0);
        md = (d < 0) ? -d : d;
        den = (md * md * 64'd1024) / s;
        for (int a = 0; a < 3; a++)
            den = den + g2[a] * g2[a];
        for (int a = 0; a < 3; a++)
            f[a] = (any && den != 0) ? demon_force(g2[a], d, den) : 32'd0;
        o.delta_x = f[0];
        o.delta_y = f[1];
        o.delta_z = f[2];
        o.updated = any;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= sdu_pkg::SPACING_RESET;
            fail_count = 0;
            n_updated = 0;
            vectors_due.delete();
            pending = 0;
        end
        else
        begin
            if (voxel.valid && voxel.ready)
                vectors_due.push_back(predict_vector(voxel.data, spacing_reg));
            if (cfg.valid && cfg.ready)
                spacing_reg <= cfg.data;
            if (delta.valid && delta.ready)
            begin
                if (vectors_due.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, delta.data);
                    fail_count++;
                end
                else
                begin
                    sdu_pkg::delta_t e;
                    e = vectors_due.pop_front();
                    if (e.updated)
                        n_updated++;
                    if (e.delta_x !== delta.data.delta_x)
                    begin
                        $display("%0t: delta_x expected %h actual %h", $time, e.delta_x,
                                 delta.data.delta_x);
                        fail_count++;
                    end
                    if (e.delta_y !== delta.data.delta_y)
                    begin
                        $display("%0t: delta_y expected %h actual %h", $time, e.delta_y,
                                 delta.data.delta_y);
                        fail_count++;
                    end
                    if (e.delta_z !== delta.data.delta_z)
                    begin
                        $display("%0t: delta_z expected %h actual %h", $time, e.delta_z,
                                 delta.data.delta_z);
                        fail_count++;
                    end
                    if (e.updated !== delta.data.updated)
                    begin
                        $display("%0t: updated expected %b actual %b", $time, e.updated,
                                 delta.data.updated);
                        fail_count++;
                    end
                end
            end
            pending = vectors_due.size();
        end
    end
endmodule

>>> tb/symmetric_demons_update_vector_test.sv
// Top of the symmetric demons update vector testbench: drives voxels and spacing writes with
// random gaps and stalls, reports the verdict. Depends on sdu_pkg, sdu_if, sdu_checker, the DUT.
module symmetric_demons_update_vector_test;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   recv_idle;
    int   idle_cycles;
    int   n_voxels;
    int   n_spacings;

    localparam int LIMIT = 5000;

    sdu_voxel_if voxel_ch();
    sdu_delta_if delta_ch();
    sdu_cfg_if   cfg_ch();

    symmetric_demons_update_vector dut (
        .clk(clk), .rst_n(rst_n), .voxel(voxel_ch.sink), .delta(delta_ch.source),
        .cfg(cfg_ch.sink)
    );

    sdu_checker checker_i (
        .clk(clk), .rst_n(rst_n), .voxel(voxel_ch.sink), .delta(delta_ch.sink),
        .cfg(cfg_ch.sink), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        voxel_ch.valid = 1'b0;
        voxel_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        delta_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            delta_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((voxel_ch.valid && voxel_ch.ready) || (delta_ch.valid && delta_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [sdu_pkg::IN_W-1:0] pick_field();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            4: return sdu_pkg::IN_W'($urandom_range(1023));
            default: return sdu_pkg::IN_W'($urandom);
        endcase
    endfunction

    function automatic sdu_pkg::voxel_t random_voxel(bit wild);
        sdu_pkg::voxel_t v;
        logic [sdu_pkg::IN_W-1:0] base;
        if (wild)
        begin
            v = {pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                 pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                 pick_field()};
        end
        else
        begin
            base = sdu_pkg::IN_W'($urandom_range(24'h7FFFFF, 24'h10000));
            v.static_grad_x = sdu_pkg::IN_W'(int'($urandom_range(8191)) - 4096);
            v.static_grad_y = sdu_pkg::IN_W'(int'($urandom_range(8191)) - 4096);
            v.static_grad_z = sdu_pkg::IN_W'(int'($urandom_range(8191)) - 4096);
            v.warped_center = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_x_prev = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_x_next = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_y_prev = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_y_next = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_z_prev = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.warped_z_next = sdu_pkg::IN_W'(base + $urandom_range(4095));
            v.static_value = ($urandom_range(7) == 0) ? v.warped_center
                                                      : sdu_pkg::IN_W'(base
                                                        + $urandom_range(4095));
        end
        return v;
    endfunction

    task automatic send_voxel(sdu_pkg::voxel_t v);
        while ($urandom_range(99) < send_idle)
        begin
            voxel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        voxel_ch.valid <= 1'b1;
        voxel_ch.data <= v;
        @(posedge clk);
        while (!voxel_ch.ready)
            @(posedge clk);
        n_voxels++;
    endtask

    task automatic drain_pipeline();
        voxel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_spacing(logic [sdu_pkg::SP_W-1:0] sp);
        drain_pipeline();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= sp;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        n_spacings++;
    endtask

    task automatic send_directed();
        sdu_pkg::voxel_t v;
        v = '0;
        send_voxel(v);
        v.warped_center = 24'd256;
        send_voxel(v);
        v = '1;
        send_voxel(v);
        v = '0;
        v.static_grad_x = 24'sh800000;
        v.static_grad_y = 24'sh7FFFFF;
        v.static_grad_z = 24'sh800000;
        v.warped_center = 24'd1;
        send_voxel(v);
        v = '0;
        v.warped_x_next = '1;
        v.warped_y_prev = '1;
        v.warped_z_next = 24'd5;
        v.static_value = '1;
        send_voxel(v);
        v = '0;
        v.static_grad_x = 24'sd1;
        v.warped_center = '1;
        send_voxel(v);
        v = '0;
        v.static_grad_y = -24'sd1;
        v.warped_center = 24'd3;
        v.static_value = 24'd4;
        send_voxel(v);
        v = '0;
        v.static_grad_z = 24'sd2;
        v.warped_z_prev = 24'd4;
        send_voxel(v);
        v = random_voxel(1'b0);
        v.static_value = v.warped_center;
        send_voxel(v);
        for (int i = 0; i < 8; i++)
            send_voxel(random_voxel(1'b1));
    endtask

    initial
    begin
        logic [sdu_pkg::SP_W-1:0] spacings[6];
        spacings = '{16'd256, 16'd0, 16'd1, 16'hFFFF, 16'd128, 16'd4000};
        send_idle = 18;
        recv_idle = 61;
        idle_cycles = 0;
        n_voxels = 0;
        n_spacings = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int p = 0; p < 6; p++)
        begin
            write_spacing(spacings[p]);
            if (p == 2)
            begin
                send_idle = 61;
                recv_idle = 18;
            end
            if (p == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (p == 1 || p == 5)
                send_directed();
            for (int i = 0; i < 145; i++)
                send_voxel(random_voxel($urandom_range(3) == 0));
        end
        write_spacing(sdu_pkg::SP_W'($urandom));
        for (int i = 0; i < 30; i++)
            send_voxel(random_voxel(1'b0));
        drain_pipeline();
        $display("Sent %0d voxels over %0d spacing settings, including zero and full scale.",
                 n_voxels, n_spacings);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
design/sdu_pkg.sv
design/sdu_if.sv
design/sdu_div_cell.sv
design/sdu_front.sv
design/symmetric_demons_update_vector.sv
tb/sdu_checker.sv
tb/symmetric_demons_update_vector_test.sv
